FILE: hw/rtl/lpg_pkg.sv
// Package: shared types, constants and sine table function for the curve point generator.
`timescale 1ns / 1ps
`default_nettype none
package lpg_pkg;

	localparam int ANGLE_BITS_DEF      = 16;
	localparam int SINE_TABLE_BITS_DEF = 10;
	localparam int AMPLITUDE_BITS_DEF  = 10;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;
	localparam int FREQ_W     = 8;
	localparam int PHASE_W    = 16;
	localparam int COUNT_W    = 16;
	localparam int Q30_W      = 31;
	// signed freq times zero-extended 16-bit t; the +1 is the zero-extension bit of t
	localparam int PROD_W     = FREQ_W + COUNT_W + 1;

	localparam logic [CFG_IDX_W-1:0] REG_FREQ_X      = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FREQ_Y      = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PHASE_X     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_PHASE_Y     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_POINT_COUNT = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_STEP_SIZE   = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_AMPLITUDE   = 3'd6;

	localparam logic [FREQ_W-1:0]  FREQ_RST   = 8'sd1;
	localparam logic [PHASE_W-1:0] PHASE_RST  = 16'd0;
	localparam logic [COUNT_W-1:0] COUNT_RST  = 16'd400;
	localparam logic [COUNT_W-1:0] STEP_RST   = 16'd164;
	localparam int                 AMP_RST    = 300;

	localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
	localparam logic [63:0] Q30_ONE     = 64'd1 << 30;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RD_X,
		ST_MUL_X,
		ST_RD_Y,
		ST_MUL_Y,
		ST_PUT
	} lpg_state_t;

	typedef struct packed {
		logic accept;
		logic rd_en;
		logic sel_y;
		logic mul_en;
		logic cap_x;
		logic load_out;
	} lpg_cmd_t;

	typedef struct packed {
		logic out_free;
	} lpg_sts_t;

	// Taylor series sine in Q30, evaluated at elaboration only
	function automatic logic [Q30_W-1:0] sin_q30(input logic [63:0] x);
		logic [63:0]        x2;
		logic [63:0]        term;
		logic [63:0]        p;
		logic signed [63:0] sum;
		x2   = (x * x) >> 30;
		term = x;
		sum  = $signed(x);
		for (int n = 1; n <= 9; n++) begin
			p = (term * x2) >> 30;
			case (n)
				1:       term = p / 64'd6;
				2:       term = p / 64'd20;
				3:       term = p / 64'd42;
				4:       term = p / 64'd72;
				5:       term = p / 64'd110;
				6:       term = p / 64'd156;
				7:       term = p / 64'd210;
				8:       term = p / 64'd272;
				default: term = p / 64'd342;
			endcase
			if ((n % 2) == 1)
				sum = sum - $signed(term);
			else
				sum = sum + $signed(term);
		end
		if (sum < 0)
			sum = 0;
		if (sum > $signed(Q30_ONE))
			sum = $signed(Q30_ONE);
		return sum[Q30_W-1:0];
	endfunction

	function automatic logic [Q30_W-1:0] sine_entry(input int k, input int tb);
		logic [63:0] arg;
		arg = (64'(k) * HALF_PI_Q30) >> tb;
		if (k == 0)
			return '0;
		else if (k == (1 << tb))
			return Q30_ONE[Q30_W-1:0];
		else
			return sin_q30(arg);
	endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/lissajous_point_generator.sv
// Top level: curve point generator, stream in and out, plain config write port.
//
// Usage:
//  Each word on the s_ side is one point tick; s_tdata[0] = 1 starts a new pass.
//  Each tick yields one word on the m_ side: x and y in m_tdata, m_tlast set on
//  the final point of a pass (the next tick begins the next pass).
//  Registers are written through cfg_we/cfg_index/cfg_wdata, one per cycle; the user
//  must write them only while no point is in flight, which the block does not enforce.
//  A tick is taken only in the idle step, so one point is in flight at a time. The
//  six steps (angle, x lookup, x scale, y lookup, y scale, output load) run in that
//  order and share one sine table and one scaling multiplier.
//  The output register holds a finished point, so a new tick is taken while
//  the receiver stalls; the next point then waits in the last step until
//  m_tready frees the register.
//  Reset (arst_n low) restores the register defaults, clears the point index,
//  sets the parameter accumulator to the default step and drops m_tvalid.
`timescale 1ns / 1ps
`default_nettype none
module lissajous_point_generator #(
	parameter int ANGLE_BITS      = lpg_pkg::ANGLE_BITS_DEF,
	parameter int SINE_TABLE_BITS = lpg_pkg::SINE_TABLE_BITS_DEF,
	parameter int AMPLITUDE_BITS  = lpg_pkg::AMPLITUDE_BITS_DEF,
	localparam int TDATA_W        = ((2 * (AMPLITUDE_BITS + 1) + 7) / 8) * 8
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_we,
	input  wire logic [lpg_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [lpg_pkg::CFG_DATA_W-1:0] cfg_wdata,
	input  wire logic                           s_tvalid,
	output logic                                s_tready,
	input  wire logic [7:0]                     s_tdata,  // restart, zero pad
	output logic                                m_tvalid,
	input  wire logic                           m_tready,
	output logic [TDATA_W-1:0]                  m_tdata,  // x_pos, y_pos, zero pad
	output logic                                m_tlast
);

	lpg_pkg::lpg_cmd_t cmd;
	lpg_pkg::lpg_sts_t sts;
	logic signed [AMPLITUDE_BITS:0] x_pos, y_pos;

	lpg_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	lpg_dpath #(
		.ANGLE_BITS      (ANGLE_BITS),
		.SINE_TABLE_BITS (SINE_TABLE_BITS),
		.AMPLITUDE_BITS  (AMPLITUDE_BITS)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.restart   (s_tdata[0]),
		.cmd       (cmd),
		.sts       (sts),
		.m_tready  (m_tready),
		.m_tvalid  (m_tvalid),
		.x_pos     (x_pos),
		.y_pos     (y_pos),
		.m_tlast   (m_tlast)
	);

	assign m_tdata = TDATA_W'({y_pos, x_pos});

`ifndef SYNTHESIS
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("tick accepted while a point is in flight");

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> sts.out_free)
		else $error("output register overwritten");

	a_cmd_excl: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.accept, cmd.rd_en, cmd.mul_en, cmd.load_out}))
		else $error("datapath commands overlap");

	a_load_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |=> m_tvalid)
		else $error("loaded point not presented");
`endif

endmodule
`default_nettype wire

FILE: hw/rtl/lpg_ctrl.sv
// Controller: sequences one point through angle, table lookup, scaling and output load.
`timescale 1ns / 1ps
`default_nettype none
module lpg_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              s_tvalid,
	output logic                   s_tready,
	input  wire lpg_pkg::lpg_sts_t sts,
	output lpg_pkg::lpg_cmd_t      cmd
);

	lpg_pkg::lpg_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= lpg_pkg::ST_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		s_tready = 1'b0;
		case (state_q)
			lpg_pkg::ST_IDLE: begin
				s_tready   = 1'b1;
				cmd.accept = s_tvalid;
				if (s_tvalid)
					state_d = lpg_pkg::ST_RD_X;
			end
			lpg_pkg::ST_RD_X: begin
				cmd.rd_en = 1'b1;
				state_d   = lpg_pkg::ST_MUL_X;
			end
			lpg_pkg::ST_MUL_X: begin
				cmd.mul_en = 1'b1;
				state_d    = lpg_pkg::ST_RD_Y;
			end
			lpg_pkg::ST_RD_Y: begin
				cmd.rd_en = 1'b1;
				cmd.sel_y = 1'b1;
				cmd.cap_x = 1'b1;
				state_d   = lpg_pkg::ST_MUL_Y;
			end
			lpg_pkg::ST_MUL_Y: begin
				cmd.mul_en = 1'b1;
				state_d    = lpg_pkg::ST_PUT;
			end
			lpg_pkg::ST_PUT: begin
				if (sts.out_free) begin
					cmd.load_out = 1'b1;
					state_d      = lpg_pkg::ST_IDLE;
				end
			end
			default: state_d = lpg_pkg::ST_IDLE;
		endcase
	end

endmodule
`default_nettype wire

FILE: hw/rtl/lpg_dpath.sv
// Datapath: config registers, pass state, angle math, sine table, scaling and output register.
`timescale 1ns / 1ps
`default_nettype none
module lpg_dpath #(
	parameter int ANGLE_BITS      = lpg_pkg::ANGLE_BITS_DEF,
	parameter int SINE_TABLE_BITS = lpg_pkg::SINE_TABLE_BITS_DEF,
	parameter int AMPLITUDE_BITS  = lpg_pkg::AMPLITUDE_BITS_DEF
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               cfg_we,
	input  wire logic [lpg_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire logic [lpg_pkg::CFG_DATA_W-1:0]     cfg_wdata,
	input  wire logic                               restart,
	input  wire lpg_pkg::lpg_cmd_t                  cmd,
	output lpg_pkg::lpg_sts_t                       sts,
	input  wire logic                               m_tready,
	output logic                                    m_tvalid,
	output logic signed [AMPLITUDE_BITS:0]          x_pos,
	output logic signed [AMPLITUDE_BITS:0]          y_pos,
	output logic                                    m_tlast
);

	localparam int OUT_W   = AMPLITUDE_BITS + 1;
	localparam int TAB_LEN = (1 << SINE_TABLE_BITS) + 1;
	localparam int D       = ANGLE_BITS - 2 - SINE_TABLE_BITS;
	localparam int PW      = lpg_pkg::PROD_W;
	localparam int MW      = AMPLITUDE_BITS + lpg_pkg::Q30_W;
	localparam logic [PW-1:0] QTR = PW'(1) << (ANGLE_BITS - 2);
	localparam logic [SINE_TABLE_BITS:0] IDX_TOP = (SINE_TABLE_BITS+1)'(1) << SINE_TABLE_BITS;
	localparam logic [MW-1:0] RND_HALF = MW'(1) << 29;

	// configuration
	logic [lpg_pkg::FREQ_W-1:0]  freq_x_q, freq_y_q;
	logic [lpg_pkg::PHASE_W-1:0] phase_x_q, phase_y_q;
	logic [lpg_pkg::COUNT_W-1:0] point_count_q, step_size_q;
	logic [AMPLITUDE_BITS-1:0]   amplitude_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			freq_x_q      <= lpg_pkg::FREQ_RST;
			freq_y_q      <= lpg_pkg::FREQ_RST;
			phase_x_q     <= lpg_pkg::PHASE_RST;
			phase_y_q     <= lpg_pkg::PHASE_RST;
			point_count_q <= lpg_pkg::COUNT_RST;
			step_size_q   <= lpg_pkg::STEP_RST;
			amplitude_q   <= AMPLITUDE_BITS'(lpg_pkg::AMP_RST);
		end else if (cfg_we) begin
			case (cfg_index)
				lpg_pkg::REG_FREQ_X:      freq_x_q      <= cfg_wdata[lpg_pkg::FREQ_W-1:0];
				lpg_pkg::REG_FREQ_Y:      freq_y_q      <= cfg_wdata[lpg_pkg::FREQ_W-1:0];
				lpg_pkg::REG_PHASE_X:     phase_x_q     <= cfg_wdata;
				lpg_pkg::REG_PHASE_Y:     phase_y_q     <= cfg_wdata;
				lpg_pkg::REG_POINT_COUNT: point_count_q <= cfg_wdata;
				lpg_pkg::REG_STEP_SIZE:   step_size_q   <= cfg_wdata;
				lpg_pkg::REG_AMPLITUDE:   amplitude_q   <= cfg_wdata[AMPLITUDE_BITS-1:0];
				default: ;
			endcase
		end
	end

	// pass state and angles
	logic [lpg_pkg::COUNT_W-1:0] index_q, acc_q;
	logic [lpg_pkg::COUNT_W-1:0] t_cur, idx_cur;
	logic                        last_cur;
	logic signed [PW-1:0]        mx, my;
	logic [PW-1:0]               sx, sy;
	logic [ANGLE_BITS-1:0]       ang_x_q, ang_y_q;
	logic                        last_q;

	assign t_cur    = restart ? step_size_q : acc_q;
	assign idx_cur  = restart ? '0 : index_q;
	assign last_cur = ({1'b0, idx_cur} + 17'd1) >= {1'b0, point_count_q};
	assign mx = PW'($signed(freq_x_q) * $signed({1'b0, t_cur}));
	assign my = PW'($signed(freq_y_q) * $signed({1'b0, t_cur}));
	assign sx = mx + PW'(phase_x_q);
	assign sy = my + PW'(phase_y_q) + QTR;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			index_q <= '0;
			acc_q   <= lpg_pkg::STEP_RST;
		end else if (cmd.accept) begin
			if (last_cur) begin
				index_q <= '0;
				acc_q   <= step_size_q;
			end else begin
				index_q <= idx_cur + 16'd1;
				acc_q   <= t_cur + step_size_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			ang_x_q <= sx[ANGLE_BITS-1:0];
			ang_y_q <= sy[ANGLE_BITS-1:0];
			last_q  <= last_cur;
		end
	end

	// quarter-wave lookup
	logic [ANGLE_BITS-1:0]      ang;
	logic [1:0]                 quad;
	logic [ANGLE_BITS-3:0]      pos;
	logic [SINE_TABLE_BITS:0]   idx_raw, idx;
	logic [lpg_pkg::Q30_W-1:0]  rom [TAB_LEN];

	assign ang  = cmd.sel_y ? ang_y_q : ang_x_q;
	assign quad = ang[ANGLE_BITS-1:ANGLE_BITS-2];
	assign pos  = ang[ANGLE_BITS-3:0];

	generate
		if (D > 0) begin : g_round
			logic [ANGLE_BITS-2:0] psum;
			assign psum    = {1'b0, pos} + (ANGLE_BITS-1)'(1 << (D - 1));
			assign idx_raw = psum[ANGLE_BITS-2:D];
		end else if (D == 0) begin : g_exact
			assign idx_raw = {1'b0, pos};
		end else begin : g_shift
			assign idx_raw = {1'b0, pos, {(-D){1'b0}}};
		end
	endgenerate

	assign idx = quad[0] ? (IDX_TOP - idx_raw) : idx_raw;

	for (genvar k = 0; k < TAB_LEN; k++) begin : g_rom
		assign rom[k] = lpg_pkg::sine_entry(k, SINE_TABLE_BITS);
	end

	logic [lpg_pkg::Q30_W-1:0] mag_q;
	logic                      neg_q, pneg_q;
	logic [MW-1:0]             prod_q;

	always_ff @(posedge clk) begin
		if (cmd.rd_en) begin
			mag_q <= rom[idx];
			neg_q <= quad[1];
		end
		if (cmd.mul_en) begin
			prod_q <= MW'(amplitude_q * mag_q);
			pneg_q <= neg_q;
		end
	end

	// round half away from zero, then apply sign
	logic [MW-1:0]             rsum;
	logic [AMPLITUDE_BITS-1:0] rmag;
	logic signed [OUT_W-1:0]   rval;
	logic signed [OUT_W-1:0]   x_q;

	assign rsum = prod_q + RND_HALF;
	assign rmag = rsum[AMPLITUDE_BITS+29:30];
	assign rval = pneg_q ? -$signed({1'b0, rmag}) : $signed({1'b0, rmag});

	always_ff @(posedge clk) begin
		if (cmd.cap_x)
			x_q <= rval;
	end

	// output register
	assign sts.out_free = !m_tvalid || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			m_tvalid <= 1'b0;
		else if (cmd.load_out)
			m_tvalid <= 1'b1;
		else if (m_tready)
			m_tvalid <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			x_pos   <= x_q;
			y_pos   <= rval;
			m_tlast <= last_q;
		end
	end

endmodule
`default_nettype wire
